### rtl/core/crc16fp_pkg.sv
// Shared types, constants and CRC-16/Modbus byte update for the frame parser.
`default_nettype none

package crc16fp_pkg;

  localparam logic [7:0]  START_BYTE = 8'hAA;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] MAX_LEN_RST = 16'd256;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CRCLO = 3'd5;
  localparam logic [2:0] PH_CRCHI = 3'd6;

  localparam int RES_DATA_W = 48;
  localparam int RES_USER_W = 3;

  typedef struct packed {
    logic [15:0] frame_len;
    logic [7:0]  frame_cmd;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
  } res_data_t;

  typedef struct packed {
    logic frame_fault;
    logic frame_ok;
    logic payload_valid;
  } res_user_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/crc16_frame_parser_top.sv
// Byte-serial frame parser with running CRC-16/Modbus check and skid-buffered output.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata: rx_byte
//   out_     out  out_tvalid/out_tready out_tdata/out_tuser: payload and frame verdict
//   cfg_     in   APB psel/penable      max_payload_len at byte address 0
//
// One beat per cycle while in_tready is high; each input beat yields one output beat.
// The parser state and the byte-wide CRC update sit between the accept edge
// and the output register; a skid register holds one beat while out_tready is low.
// Reset is synchronous: phase returns to hunting, CRC to 0xFFFF, limit to 256.
// in_tready drops only while the skid register is full.
`default_nettype none

module crc16_frame_parser_top import crc16fp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                        // [31:24] frame_cmd, [47:32] frame_len
  output      logic [2:0]  out_tuser,   // [0] payload_valid, [1] frame_ok, [2] frame_fault
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  logic [15:0] max_len_r;
  logic [2:0]  phase_r,   phase_nxt;
  logic [7:0]  cmd_r,     cmd_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [15:0] count_r,   count_nxt;
  logic [7:0]  crc_lo_r,  crc_lo_nxt;
  logic [15:0] crc_r,     crc_nxt;

  res_data_t   res_data;
  res_user_t   res_user;

  res_data_t   out_data_r;
  res_user_t   out_user_r;
  logic        out_valid_r;
  res_data_t   skid_data_r;
  res_user_t   skid_user_r;
  logic        skid_valid_r;

  logic        in_fire;
  logic        cfg_wr;
  logic [15:0] crc_upd;
  logic [15:0] len_lo;
  logic [15:0] count_inc;

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, max_len_r};

  assign crc_upd   = crc_byte(crc_r, in_tdata);
  assign len_lo    = {len_r[15:8], in_tdata};
  assign count_inc = count_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    crc_lo_nxt = crc_lo_r;
    crc_nxt    = crc_r;
    res_user   = '0;
    res_data.payload_byte  = 8'd0;
    res_data.payload_index = 16'd0;
    unique case (phase_r)
      PH_CMD: begin
        cmd_nxt   = in_tdata;
        crc_nxt   = crc_upd;
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        len_nxt   = {in_tdata, 8'd0};
        crc_nxt   = crc_upd;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_nxt = len_lo;
        crc_nxt = crc_upd;
        priority if (len_lo == 16'd0) begin
          phase_nxt = PH_CRCLO;
        end else if (len_lo > max_len_r) begin
          res_user.frame_fault = 1'b1;
          phase_nxt = PH_HUNT;
        end else begin
          count_nxt = 16'd0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        res_user.payload_valid = 1'b1;
        res_data.payload_byte  = in_tdata;
        res_data.payload_index = count_r;
        crc_nxt   = crc_upd;
        count_nxt = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        crc_lo_nxt = in_tdata;
        phase_nxt  = PH_CRCHI;
      end
      PH_CRCHI: begin
        if ({in_tdata, crc_lo_r} == crc_r) begin
          res_user.frame_ok = 1'b1;
        end else begin
          res_user.frame_fault = 1'b1;
        end
        phase_nxt = PH_HUNT;
      end
      default: begin
        if (in_tdata == START_BYTE) begin
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_CMD;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
    res_data.frame_cmd = cmd_nxt;
    res_data.frame_len = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cmd_r    <= 8'd0;
      len_r    <= 16'd0;
      count_r  <= 16'd0;
      crc_lo_r <= 8'd0;
      crc_r    <= CRC_INIT;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      crc_lo_r <= crc_lo_nxt;
      crc_r    <= crc_nxt;
    end
  end

  // advance the output register; park a new beat in the skid stage while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end else if (in_fire) begin
        out_data_r <= res_data;
        out_user_r <= res_user;
      end
    end else if (in_fire) begin
      skid_data_r <= res_data;
      skid_user_r <= res_user;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire
